/* hdl/mkd_pkg.sv */
// Package for the matrix keypad debounce block: item types, key record, keymap.
// No dependencies; used by every module under hdl.
`default_nettype none
package mkd_pkg;

  localparam int unsigned MatrixW  = 16;
  localparam int unsigned StampW   = 32;
  localparam int unsigned DebW     = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CodeW    = 7;
  localparam logic [DebW-1:0] DebounceReset = 16'd20;

  typedef struct packed {
    logic [MatrixW-1:0] pressed_matrix;
    logic [StampW-1:0]  now_ms;
  } mkd_in_t;

  typedef struct packed {
    logic             key_valid;
    logic [CodeW-1:0] key_code;
    logic [IdxW-1:0]  key_index;
  } mkd_out_t;

  typedef struct packed {
    logic             single;
    logic [IdxW-1:0]  idx;
    logic [CodeW-1:0] code;
  } mkd_key_t;

  function automatic logic [CodeW-1:0] key_char(input logic [IdxW-1:0] idx);
    logic [CodeW-1:0] c;
    case (idx)
      4'd0:    c = 7'h31; // '1'
      4'd1:    c = 7'h32; // '2'
      4'd2:    c = 7'h33; // '3'
      4'd3:    c = 7'h41; // 'A'
      4'd4:    c = 7'h34; // '4'
      4'd5:    c = 7'h35; // '5'
      4'd6:    c = 7'h36; // '6'
      4'd7:    c = 7'h42; // 'B'
      4'd8:    c = 7'h37; // '7'
      4'd9:    c = 7'h38; // '8'
      4'd10:   c = 7'h39; // '9'
      4'd11:   c = 7'h43; // 'C'
      4'd12:   c = 7'h2A; // '*'
      4'd13:   c = 7'h30; // '0'
      4'd14:   c = 7'h23; // '#'
      4'd15:   c = 7'h44; // 'D'
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/mkd_decode.sv */
// Single-key qualifier: checks that exactly one matrix bit is set and encodes it.
// Depends on mkd_pkg (key record, keymap).
`default_nettype none
module mkd_decode (
  input  wire logic [mkd_pkg::MatrixW-1:0] matrix,
  output mkd_pkg::mkd_key_t                key
);
  import mkd_pkg::*;

  logic [IdxW-1:0] idx;

  always_comb begin
    idx = '0;
    for (int i = 0; i < MatrixW; i++) begin
      if (matrix[i]) begin
        idx = idx | IdxW'(i);
      end
    end
  end

  always_comb begin
    key.single = (matrix != '0) && ((matrix & (matrix - MatrixW'(1))) == '0);
    key.idx    = idx;
    key.code   = key_char(idx);
  end

endmodule
`default_nettype wire

/* hdl/mkd_track.sv */
// Debounce state: candidate key, its stamp and the last reported key.
// Depends on mkd_pkg; forms the result for the item that advances this cycle.
`default_nettype none
module mkd_track (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire mkd_pkg::mkd_key_t          key,
  input  wire logic [mkd_pkg::StampW-1:0] now_ms,
  input  wire logic [mkd_pkg::DebW-1:0]   debounce_ms,
  output mkd_pkg::mkd_out_t               result
);
  import mkd_pkg::*;

  logic              cand_valid, cand_valid_next;
  logic [IdxW-1:0]   cand_idx, cand_idx_next;
  logic [StampW-1:0] cand_stamp, cand_stamp_next;
  logic              rep_valid, rep_valid_next;
  logic [IdxW-1:0]   rep_idx, rep_idx_next;
  logic [StampW-1:0] elapsed;
  logic              settled;

  assign elapsed = now_ms - cand_stamp;
  assign settled = elapsed >= {{(StampW-DebW){1'b0}}, debounce_ms};

  always_comb begin
    cand_valid_next = cand_valid;
    cand_idx_next   = cand_idx;
    cand_stamp_next = cand_stamp;
    rep_valid_next  = rep_valid;
    rep_idx_next    = rep_idx;
    result          = '0;
    if (!key.single) begin
      cand_valid_next = 1'b0;
      rep_valid_next  = 1'b0;
    end else if (!cand_valid || cand_idx != key.idx) begin
      cand_valid_next = 1'b1;
      cand_idx_next   = key.idx;
      cand_stamp_next = now_ms;
    end else if (settled && !(rep_valid && rep_idx == key.idx)) begin
      rep_valid_next   = 1'b1;
      rep_idx_next     = key.idx;
      result.key_valid = 1'b1;
      result.key_code  = key.code;
      result.key_index = key.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
      rep_valid  <= 1'b0;
    end else if (advance) begin
      cand_valid <= cand_valid_next;
      rep_valid  <= rep_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cand_idx   <= cand_idx_next;
      cand_stamp <= cand_stamp_next;
      rep_idx    <= rep_idx_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/matrix_keypad_debounce.sv */
// Top level of the 4x4 matrix keypad debounce block.
// Depends on mkd_pkg, mkd_decode and mkd_track.
//
// Each accepted poll item gives exactly one result item, once the output is
// free: an input register, then decode and debounce logic, then the result
// register. One poll is taken every cycle while the result side keeps up;
// in_ready follows out_ready through the two stages. debounce_ms resets
// to 20 and is written through the cfg channel, which is always ready;
// write it only while no poll is in flight.
`default_nettype none
module matrix_keypad_debounce (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire mkd_pkg::mkd_in_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output mkd_pkg::mkd_out_t                out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mkd_pkg::DebW-1:0]    cfg_data
);
  import mkd_pkg::*;

  logic              s1_valid;
  mkd_in_t           s1_data;
  logic              advance;
  logic [DebW-1:0]   debounce_ms;
  mkd_key_t          key;
  mkd_out_t          result;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DebounceReset;
    end else if (cfg_valid) begin
      debounce_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  mkd_decode u_decode (
    .matrix (s1_data.pressed_matrix),
    .key    (key)
  );

  mkd_track u_track (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .key         (key),
    .now_ms      (s1_data.now_ms),
    .debounce_ms (debounce_ms),
    .result      (result)
  );

endmodule
`default_nettype wire

/* sim/keypad_report_checker.sv */
// Checker for matrix_keypad_debounce: watches the poll, result and cfg channels,
// predicts each result item from its own debounce state and compares field by field.
// Depends on mkd_pkg for the item types and the debounce reset value.
`timescale 1ns / 100ps
module keypad_report_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  mkd_pkg::mkd_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  mkd_pkg::mkd_out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [15:0]       cfg_data,
  output int                fails,
  output int                pending
);
  import mkd_pkg::*;

  localparam logic [127:0] KEY_LEGEND = "123A456B789C*0#D";

  logic [DebW-1:0]   debounce_ms;
  logic [CodeW-1:0]  reported_code;
  logic [CodeW-1:0]  candidate_code;
  logic [StampW-1:0] candidate_since;
  mkd_out_t          expected_reports[$];

  initial begin
    fails   = 0;
    pending = 0;
  end

  function automatic mkd_out_t predict_report(input logic [15:0] m, input logic [31:0] t);
    mkd_out_t         r;
    int               pos;
    logic [CodeW-1:0] c;
    logic [31:0]      elapsed;
    r = '0;
    if (m == 16'h0 || (m & (m - 16'h1)) != 16'h0) begin
      reported_code   = '0;
      candidate_code  = '0;
      candidate_since = '0;
      return r;
    end
    pos = 0;
    for (int i = 0; i < 16; i++) if (m[i]) pos = i;
    c = KEY_LEGEND[(15 - pos) * 8 +: 7];
    if (c != candidate_code) begin
      candidate_code  = c;
      candidate_since = t;
      return r;
    end
    elapsed = t - candidate_since;
    if (elapsed < {16'h0, debounce_ms}) return r;
    if (c == reported_code) return r;
    reported_code = c;
    r.key_valid = 1'b1;
    r.key_code  = c;
    r.key_index = pos[3:0];
    return r;
  endfunction

  always @(posedge clk) begin
    mkd_out_t want;
    if (rst) begin
      debounce_ms     = DebounceReset;
      reported_code   = '0;
      candidate_code  = '0;
      candidate_since = '0;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("result item with no poll waiting: key_valid %0d key_code %0h key_index %0d",
                 out_data.key_valid, out_data.key_code, out_data.key_index);
          fails++;
        end else begin
          want = expected_reports.pop_front();
          if (out_data.key_valid !== want.key_valid) begin
            $error("key_valid: expected %0d, got %0d", want.key_valid, out_data.key_valid);
            fails++;
          end
          if (out_data.key_code !== want.key_code) begin
            $error("key_code: expected %0h, got %0h", want.key_code, out_data.key_code);
            fails++;
          end
          if (out_data.key_index !== want.key_index) begin
            $error("key_index: expected %0d, got %0d", want.key_index, out_data.key_index);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) debounce_ms = cfg_data;
      if (in_valid && in_ready)
        expected_reports.push_back(predict_report(in_data.pressed_matrix, in_data.now_ms));
    end
    pending = expected_reports.size();
  end
endmodule

/* sim/matrix_keypad_debounce_tb.sv */
// Testbench top for matrix_keypad_debounce: drives polls and debounce writes
// with random gaps and stalls, and gives the verdict from keypad_report_checker.
// Depends on mkd_pkg, the block under hdl and sim/keypad_report_checker.sv.
`timescale 1ns / 100ps
module matrix_keypad_debounce_tb;
  import mkd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  mkd_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  mkd_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          fails;
  int          pending;

  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [15:0] deb_now = DebounceReset;
  logic [31:0] t_ms = '0;
  int          n_sent = 0;
  int          quiet = 0;

  always #1 clk = ~clk;

  matrix_keypad_debounce u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  keypad_report_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer(input logic [15:0] m, input logic [31:0] t);
    int gap;
    in_data  <= '{pressed_matrix: m, now_ms: t};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_sent++;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_debounce(input logic [15:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    deb_now = v;
  endtask

  // press and hold a key near the debounce edge, may switch, then may release
  task automatic key_sequence();
    int          k;
    int          nk;
    int          hold;
    logic [31:0] press_t;
    logic [15:0] m;
    k = $urandom_range(0, 15);
    hold = $urandom_range(1, 12);
    press_t = t_ms;
    for (int i = 0; i < hold; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        nk = $urandom_range(0, 15);
        if (nk != k) press_t = t_ms;
        k = nk;
      end
      offer(16'h1 << k, t_ms);
      case ($urandom_range(0, 4))
        0:       t_ms = press_t + deb_now - 32'd1;
        1:       t_ms = press_t + deb_now;
        2:       t_ms = t_ms + $urandom_range(0, deb_now / 4 + 1);
        3:       t_ms = t_ms + $urandom_range(0, 3);
        default: t_ms = press_t + deb_now + $urandom_range(0, 100);
      endcase
    end
    case ($urandom_range(0, 3))
      0, 1: offer(16'h0, t_ms);
      2: begin
        m = (16'h1 << $urandom_range(0, 15)) | (16'h1 << $urandom_range(0, 15));
        offer(m, t_ms);
      end
      default: ;
    endcase
    t_ms = t_ms + $urandom_range(0, 5);
  endtask

  // receiver: ready runs, random stalls, one long hold when asked
  initial begin
    int ready_left;
    int stall_left;
    bit hold_done;
    ready_left = 0;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (ready_left > 0) begin
        out_ready <= 1'b1;
        ready_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(0, 39);
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int          r;
    int          phase_end;
    logic [15:0] deb;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset debounce of 20
    offer(16'h0000, 32'd1000);
    offer(16'h0001, 32'd1000);
    offer(16'h0001, 32'd1019);
    offer(16'h0001, 32'd1020);
    offer(16'h0001, 32'd5000);
    offer(16'h8000, 32'd5001);
    offer(16'h8000, 32'd5021);
    offer(16'h8001, 32'd5022);
    offer(16'hFFFF, 32'd5023);
    offer(16'h8000, 32'hFFFF_FFF0);
    offer(16'h8000, 32'h0000_0004);
    wait_idle();
    write_debounce(16'd0);
    offer(16'h0400, 32'd7);
    offer(16'h0400, 32'd7);
    offer(16'h0400, 32'd7);
    wait_idle();
    write_debounce(16'hFFFF);
    offer(16'h1000, 32'd0);
    offer(16'h1000, 32'd65534);
    offer(16'h1000, 32'd65535);
    offer(16'h0000, 32'd65536);
    offer(16'h1000, 32'hFFFF_FFFF);
    offer(16'h1000, 32'd65534);

    t_ms = $urandom();
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0:       deb = 16'd0;
        1:       deb = 16'hFFFF;
        2:       deb = 16'd1;
        default: deb = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(2, 60));
      endcase
      write_debounce(deb);
      gaps_on = (ph != 2 && ph != 3);
      if (ph == 3) hold_req = 1'b1;
      if ($urandom_range(0, 2) == 0) t_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
      phase_end = 21 + (ph + 1) * 250;
      while (n_sent < phase_end) begin
        r = $urandom_range(0, 19);
        if (r < 15) key_sequence();
        else if (r < 19) offer(16'($urandom_range(0, 65535)), $urandom());
        else wait_idle();
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* matrix_keypad_debounce.f */
hdl/mkd_pkg.sv
hdl/mkd_decode.sv
hdl/mkd_track.sv
hdl/matrix_keypad_debounce.sv
sim/keypad_report_checker.sv
sim/matrix_keypad_debounce_tb.sv
